// ===== rtl/pjh_pkg.sv =====
// pjh_pkg: shared types, codes and the rank compare of the job heap scheduler.
// No dependencies; imported by pjh_rsp_stage, priority_job_heap_scheduler and the testbench.
package pjh_pkg;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   // one heap slot as held in the entry memory
   typedef struct packed {
      logic [7:0]  prio;
      logic [31:0] seq;
      logic [15:0] ident;
      logic [15:0] runtime;
      logic [31:0] arrival;
   } entry_type;

   // one result item on its way to the response channel
   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] ident;
      logic [7:0]  prio;
      logic [31:0] wait_ticks;
      logic [31:0] turn_ticks;
      logic [6:0]  occupancy;
   } res_type;

   // true when a ranks strictly above b: higher priority, then older sequence
   function automatic logic ranks_above(entry_type a, entry_type b);
      logic r;
      if (a.prio != b.prio) begin
         r = (a.prio > b.prio);
      end else begin
         r = (a.seq < b.seq);
      end
      return r;
   endfunction

endpackage

// ===== rtl/pjh_rsp_stage.sv =====
// pjh_rsp_stage: output register of the response channel.
// Depends on pjh_pkg (res_type).
module pjh_rsp_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  pjh_pkg::res_type  res,
   output logic              free,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_status,
   output logic [15:0]       rsp_served_ident,
   output logic [7:0]        rsp_served_priority,
   output logic [31:0]       rsp_wait_ticks,
   output logic [31:0]       rsp_turnaround_ticks,
   output logic [6:0]        rsp_occupancy
);
   import pjh_pkg::*;

   logic    valid_ff, valid_in;
   res_type data_ff;

   // slot frees when empty or when the held result transfers this cycle
   assign free     = !valid_ff || rsp_ready;
   assign valid_in = load ? 1'b1 : (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= res;
      end
   end

   assign rsp_valid            = valid_ff;
   assign rsp_status           = data_ff.status;
   assign rsp_served_ident     = data_ff.ident;
   assign rsp_served_priority  = data_ff.prio;
   assign rsp_wait_ticks       = data_ff.wait_ticks;
   assign rsp_turnaround_ticks = data_ff.turn_ticks;
   assign rsp_occupancy        = data_ff.occupancy;

endmodule

// ===== rtl/priority_job_heap_scheduler.sv =====
// priority_job_heap_scheduler: priority job queue on a binary max-heap in one RAM.
// Depends on pjh_pkg and pjh_rsp_stage.
//
//  channel | ports                         | dir | transfer when
//  --------+-------------------------------+-----+--------------------------
//  req     | req_opcode, req_job_*         | in  | req_valid && req_ready
//  rsp     | rsp_status, rsp_served_*, ... | out | rsp_valid && rsp_ready
//
// Sifting: push on full and pop on empty go straight to the output state; a
//   sift moves the entry at most log2(HEAP_DEPTH) heap levels. The entry RAM
//   (one write, two registered reads) is read for the next level while the
//   current level is written back.
// Reset: synchronous; clears count, sequence number and tick. RAM contents are
//   not cleared: only entries below the count are ever used.
// Stalls: req_ready is high only between operations; a finished result waits
//   in the output register, so a new request is taken while it is unclaimed.
module priority_job_heap_scheduler #(
   parameter int HEAP_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [7:0]  req_job_priority,
   input  logic [15:0] req_job_ident,
   input  logic [15:0] req_job_runtime,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_served_ident,
   output logic [7:0]  rsp_served_priority,
   output logic [31:0] rsp_wait_ticks,
   output logic [31:0] rsp_turnaround_ticks,
   output logic [6:0]  rsp_occupancy
);
   import pjh_pkg::*;

   localparam int ADDR_W = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
   localparam int CNT_W  = $clog2(HEAP_DEPTH + 1);
   localparam int IDX_W  = ADDR_W + 2;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_UP   = 5'b00010,
      S_POP  = 5'b00100,
      S_DOWN = 5'b01000,
      S_OUT  = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [31:0]       seq_ff, seq_in;
   logic [31:0]       tick_ff, tick_in;
   logic [ADDR_W-1:0] hole_ff, hole_in;
   entry_type         mov_ff, mov_in;   // entry being sifted
   res_type           res_ff, res_in;

   // entry RAM: one write port, two registered read ports
   entry_type         heap_mem_ff [HEAP_DEPTH];
   entry_type         rd_a_ff, rd_b_ff;
   logic              we;
   logic [ADDR_W-1:0] wa, ra_a, ra_b;
   entry_type         wd;

   logic              stage_free, load;
   res_type           res_out;

   // index helpers
   logic [ADDR_W-1:0] up_parent, up_grand, push_parent, last_addr;
   logic [IDX_W-1:0]  cnt_x, lidx, ridx, best_idx, child_l, child_r;
   logic              pick_r, is_full;
   entry_type         best_ent;
   logic [31:0]       pop_wait;

   assign cnt_x       = IDX_W'(cnt_ff);
   assign is_full     = (cnt_x >= IDX_W'(HEAP_DEPTH));
   assign push_parent = ADDR_W'((cnt_ff - CNT_W'(1)) >> 1);
   assign last_addr   = ADDR_W'(cnt_ff - CNT_W'(1));
   assign up_parent   = (hole_ff - ADDR_W'(1)) >> 1;
   assign up_grand    = (up_parent - ADDR_W'(1)) >> 1;
   assign lidx        = IDX_W'({hole_ff, 1'b1});
   assign ridx        = lidx + IDX_W'(1);
   assign pick_r      = (ridx < cnt_x) && ranks_above(rd_b_ff, rd_a_ff);
   assign best_idx    = pick_r ? ridx : lidx;
   assign best_ent    = pick_r ? rd_b_ff : rd_a_ff;
   assign child_l     = IDX_W'({best_idx, 1'b1});
   assign child_r     = child_l + IDX_W'(1);
   assign pop_wait    = tick_ff - rd_a_ff.arrival;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      seq_in   = seq_ff;
      tick_in  = tick_ff;
      hole_in  = hole_ff;
      mov_in   = mov_ff;
      res_in   = res_ff;
      we       = 1'b0;
      wa       = hole_ff;
      wd       = mov_ff;
      ra_a     = '0;
      ra_b     = '0;
      load     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               res_in = '0;
               if (req_opcode == OP_PUSH) begin
                  if (is_full) begin
                     res_in.status = STATUS_FULL;
                     state_in      = S_OUT;
                  end else begin
                     seq_in         = seq_ff + 32'd1;
                     mov_in.prio    = req_job_priority;
                     mov_in.seq     = seq_ff + 32'd1;
                     mov_in.ident   = req_job_ident;
                     mov_in.runtime = req_job_runtime;
                     mov_in.arrival = tick_ff;
                     hole_in        = ADDR_W'(cnt_ff);
                     cnt_in         = cnt_ff + CNT_W'(1);
                     ra_a           = push_parent;
                     state_in       = S_UP;
                  end
               end else if (cnt_ff == '0) begin
                  res_in.status = STATUS_EMPTY;
                  state_in      = S_OUT;
               end else begin
                  ra_a     = '0;
                  ra_b     = last_addr;
                  cnt_in   = cnt_ff - CNT_W'(1);
                  state_in = S_POP;
               end
            end
         end
         S_UP: begin
            // rd_a_ff holds the parent of the hole
            we = 1'b1;
            if (hole_ff == '0 || !ranks_above(mov_ff, rd_a_ff)) begin
               wd       = mov_ff;
               state_in = S_OUT;
            end else begin
               wd      = rd_a_ff;
               hole_in = up_parent;
               ra_a    = up_grand;
            end
         end
         S_POP: begin
            // rd_a_ff is the root, rd_b_ff the last entry
            res_in.status     = STATUS_OK;
            res_in.ident      = rd_a_ff.ident;
            res_in.prio       = rd_a_ff.prio;
            res_in.wait_ticks = pop_wait;
            res_in.turn_ticks = pop_wait + 32'(rd_a_ff.runtime);
            tick_in           = tick_ff + 32'(rd_a_ff.runtime);
            mov_in            = rd_b_ff;
            hole_in           = '0;
            ra_a              = ADDR_W'(1);
            ra_b              = ADDR_W'(2);
            state_in          = (cnt_ff == '0) ? S_OUT : S_DOWN;
         end
         S_DOWN: begin
            // rd_a_ff / rd_b_ff hold the left / right child of the hole
            we = 1'b1;
            if (lidx >= cnt_x || !ranks_above(best_ent, mov_ff)) begin
               wd       = mov_ff;
               state_in = S_OUT;
            end else begin
               wd      = best_ent;
               hole_in = ADDR_W'(best_idx);
               ra_a    = child_l[ADDR_W-1:0];
               ra_b    = child_r[ADDR_W-1:0];
            end
         end
         S_OUT: begin
            if (stage_free) begin
               load     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         seq_ff   <= '0;
         tick_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         seq_ff   <= seq_in;
         tick_ff  <= tick_in;
      end
   end

   always_ff @(posedge clock) begin
      hole_ff <= hole_in;
      mov_ff  <= mov_in;
      res_ff  <= res_in;
   end

   // while a sift goes on, write and reads never hit the same entry: reads go
   // to the ancestors or the grandchildren of the slot being written
   always_ff @(posedge clock) begin
      if (we) begin
         heap_mem_ff[wa] <= wd;
      end
      rd_a_ff <= heap_mem_ff[ra_a];
      rd_b_ff <= heap_mem_ff[ra_b];
   end

   always_comb begin
      res_out           = res_ff;
      res_out.occupancy = 7'(cnt_ff);
   end

   pjh_rsp_stage u_rsp (
      .clock                (clock),
      .reset                (reset),
      .load                 (load),
      .res                  (res_out),
      .free                 (stage_free),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_status           (rsp_status),
      .rsp_served_ident     (rsp_served_ident),
      .rsp_served_priority  (rsp_served_priority),
      .rsp_wait_ticks       (rsp_wait_ticks),
      .rsp_turnaround_ticks (rsp_turnaround_ticks),
      .rsp_occupancy        (rsp_occupancy)
   );

   // the count never passes the heap size
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_x <= IDX_W'(HEAP_DEPTH))
      else $error("entry count beyond heap depth");

   // sift writes stay inside the live part of the heap
   a_write_live: assert property (@(posedge clock) disable iff (reset)
      we |-> (IDX_W'(wa) < cnt_x))
      else $error("heap write outside live entries");

   // a rejected push leaves count and sequence number alone
   a_full_noop: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_opcode == OP_PUSH && is_full)
      |=> ($stable(cnt_ff) && $stable(seq_ff)))
      else $error("push on full changed state");

   // an empty-pop result reports an empty heap
   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_EMPTY) |-> (rsp_occupancy == 7'd0))
      else $error("empty pop with nonzero occupancy");

endmodule

// ===== test/priority_job_heap_scheduler_tb.sv =====
`timescale 1ns / 1ps
// priority_job_heap_scheduler_tb: self-checking bench for the job heap scheduler.
// Uses pjh_pkg and priority_job_heap_scheduler; keeps its own heap shadow to predict results.
module priority_job_heap_scheduler_tb;
   import pjh_pkg::*;

   localparam int HEAP_DEPTH = 64;
   localparam int RANDOM_ITEMS = 1850;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE_CYCLES = 16;

   // traffic shapes for the random part
   localparam int MODE_FILL  = 0;
   localparam int MODE_DRAIN = 1;
   localparam int MODE_MIXED = 2;

   localparam int PRIO_WIDE     = 0;
   localparam int PRIO_NARROW   = 1;
   localparam int PRIO_EXTREMES = 2;

   // Shadow of the heap: predicts each result and holds the outstanding ones.
   class heap_ledger;
      entry_type slots[HEAP_DEPTH];
      int unsigned count;
      logic [31:0] seq_num;
      logic [31:0] tick;
      res_type due_results[$];
      int unsigned errors;

      function new();
         count = 0;
         seq_num = '0;
         tick = '0;
         errors = 0;
      endfunction

      // higher priority first, then the smaller sequence number
      function bit outranks(entry_type a, entry_type b);
         return {a.prio, ~a.seq} > {b.prio, ~b.seq};
      endfunction

      function void swap_slots(int unsigned a, int unsigned b);
         entry_type tmp;
         tmp = slots[a];
         slots[a] = slots[b];
         slots[b] = tmp;
      endfunction

      // apply one accepted request and queue the result it must produce
      function void note_op(logic op, logic [7:0] prio, logic [15:0] ident,
                            logic [15:0] runtime);
         res_type r;
         entry_type job;
         int unsigned i;
         int unsigned par;
         int unsigned l;
         int unsigned best;
         r = '0;
         if (op == OP_PUSH) begin
            if (count >= HEAP_DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               seq_num = seq_num + 32'd1;
               job.prio = prio;
               job.seq = seq_num;
               job.ident = ident;
               job.runtime = runtime;
               job.arrival = tick;
               i = count;
               slots[i] = job;
               count++;
               while (i > 0) begin
                  par = (i - 1) >> 1;
                  if (!outranks(slots[i], slots[par])) break;
                  swap_slots(i, par);
                  i = par;
               end
               r.status = STATUS_OK;
            end
         end else begin
            if (count == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               job = slots[0];
               r.status = STATUS_OK;
               r.ident = job.ident;
               r.prio = job.prio;
               r.wait_ticks = tick - job.arrival;
               r.turn_ticks = r.wait_ticks + {16'd0, job.runtime};
               tick = tick + {16'd0, job.runtime};
               count--;
               if (count > 0) slots[0] = slots[count];
               i = 0;
               forever begin
                  l = 2 * i + 1;
                  if (l >= count) break;
                  best = l;
                  if (l + 1 < count && outranks(slots[l + 1], slots[l])) best = l + 1;
                  if (!outranks(slots[best], slots[i])) break;
                  swap_slots(i, best);
                  i = best;
               end
            end
         end
         r.occupancy = count[6:0];
         due_results.insert(due_results.size(), r);
      endfunction

      function void match_result(res_type got);
         res_type want;
         if (due_results.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result: status %0d ident %h prio %0d occ %0d",
                        got.status, got.ident, got.prio, got.occupancy);
            return;
         end
         want = due_results.pop_front();
         if (got.status !== want.status || got.ident !== want.ident ||
             got.prio !== want.prio || got.wait_ticks !== want.wait_ticks ||
             got.turn_ticks !== want.turn_ticks || got.occupancy !== want.occupancy) begin
            errors++;
            if (errors <= 10) begin
               $display("mismatch expected: status %0d ident %h prio %0d wait %0d turn %0d occ %0d",
                        want.status, want.ident, want.prio, want.wait_ticks,
                        want.turn_ticks, want.occupancy);
               $display("         actual:   status %0d ident %h prio %0d wait %0d turn %0d occ %0d",
                        got.status, got.ident, got.prio, got.wait_ticks,
                        got.turn_ticks, got.occupancy);
            end
         end
      endfunction

      function int unsigned pending();
         return due_results.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_opcode;
   logic [7:0]  req_job_priority;
   logic [15:0] req_job_ident;
   logic [15:0] req_job_runtime;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_served_ident;
   logic [7:0]  rsp_served_priority;
   logic [31:0] rsp_wait_ticks;
   logic [31:0] rsp_turnaround_ticks;
   logic [6:0]  rsp_occupancy;

   heap_ledger ledger = new();
   int unsigned cycle_count = 0;
   res_type observed;

   priority_job_heap_scheduler #(
      .HEAP_DEPTH(HEAP_DEPTH)
   ) dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_opcode           (req_opcode),
      .req_job_priority     (req_job_priority),
      .req_job_ident        (req_job_ident),
      .req_job_runtime      (req_job_runtime),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_status           (rsp_status),
      .rsp_served_ident     (rsp_served_ident),
      .rsp_served_priority  (rsp_served_priority),
      .rsp_wait_ticks       (rsp_wait_ticks),
      .rsp_turnaround_ticks (rsp_turnaround_ticks),
      .rsp_occupancy        (rsp_occupancy)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("priority_job_heap_scheduler test failed");
         $finish;
      end
   end

   // Result monitor: values seen here are the ones from before the edge, so a
   // transfer is exactly valid && ready as the flops saw them.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         observed.status = rsp_status;
         observed.ident = rsp_served_ident;
         observed.prio = rsp_served_priority;
         observed.wait_ticks = rsp_wait_ticks;
         observed.turn_ticks = rsp_turnaround_ticks;
         observed.occupancy = rsp_occupancy;
         ledger.match_result(observed);
      end
   end

   // Receiver back-pressure: stretches of free flow, stretches with short
   // random stalls, and now and then a long stall.
   initial begin
      int unsigned burst;
      bit choppy;
      rsp_ready = 1'b0;
      forever begin
         burst = $urandom_range(20, 200);
         choppy = ($urandom_range(0, 3) != 0);
         repeat (burst) begin
            @(negedge clock);
            rsp_ready = choppy ? ($urandom_range(0, 3) != 0) : 1'b1;
         end
         if ($urandom_range(0, 5) == 0) begin
            @(negedge clock);
            rsp_ready = 1'b0;
            repeat ($urandom_range(10, 40)) @(negedge clock);
         end
      end
   end

   // Sender gap length: mostly back to back, some short, a few long.
   function automatic int unsigned gap_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] pick_priority(int style, logic [7:0] base);
      logic [7:0] p;
      case (style)
         PRIO_NARROW:   p = base + 8'($urandom_range(0, 2));
         PRIO_EXTREMES: p = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
         default:       p = 8'($urandom_range(0, 255));
      endcase
      return p;
   endfunction

   // One request transfer: present at the falling edge, hold until taken.
   // valid stays high into the next call when no gap follows.
   task automatic send_item(logic op, logic [7:0] prio, logic [15:0] ident,
                            logic [15:0] runtime);
      @(negedge clock);
      req_valid = 1'b1;
      req_opcode = op;
      req_job_priority = prio;
      req_job_ident = ident;
      req_job_runtime = runtime;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      ledger.note_op(op, prio, ident, runtime);
   endtask

   task automatic idle_after(bit enabled);
      int unsigned n;
      n = enabled ? gap_len() : 0;
      if (n > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   task automatic send_gapped(logic op, logic [7:0] prio, logic [15:0] ident,
                              logic [15:0] runtime);
      send_item(op, prio, ident, runtime);
      idle_after(1'b1);
   endtask

   initial begin
      int unsigned issued;
      int unsigned run;
      int unsigned k;
      int unsigned push_pct;
      int mode;
      int prio_style;
      bit idle_on;
      logic [7:0] prio_base;
      logic op;

      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = OP_PUSH;
      req_job_priority = '0;
      req_job_ident = '0;
      req_job_runtime = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: pop on empty, field extremes, ties at equal priority
      // (served oldest first), priority zero as a normal job, alternating
      // bit patterns, and a drain back to empty.
      send_gapped(OP_POP, 8'hFF, 16'hFFFF, 16'hFFFF);
      send_gapped(OP_PUSH, 8'd0, 16'h0000, 16'h0000);
      send_gapped(OP_PUSH, 8'd255, 16'hFFFF, 16'hFFFF);
      send_gapped(OP_PUSH, 8'd128, 16'h1234, 16'd1);
      send_gapped(OP_PUSH, 8'd128, 16'h5678, 16'd2);
      send_gapped(OP_PUSH, 8'd128, 16'hABCD, 16'd3);
      send_gapped(OP_PUSH, 8'd0, 16'h00FF, 16'h8000);
      send_gapped(OP_PUSH, 8'h55, 16'hAAAA, 16'h5555);
      send_gapped(OP_PUSH, 8'hAA, 16'h5555, 16'hAAAA);
      send_gapped(OP_POP, 8'd0, 16'd0, 16'd0);
      send_gapped(OP_POP, 8'd0, 16'd0, 16'd0);
      send_gapped(OP_POP, 8'd0, 16'd0, 16'd0);
      send_gapped(OP_POP, 8'd0, 16'd0, 16'd0);
      send_gapped(OP_PUSH, 8'd128, 16'h0001, 16'h0000);
      send_gapped(OP_POP, 8'd0, 16'd0, 16'd0);
      send_gapped(OP_POP, 8'd0, 16'd0, 16'd0);
      send_gapped(OP_POP, 8'd0, 16'd0, 16'd0);
      send_gapped(OP_POP, 8'd0, 16'd0, 16'd0);
      send_gapped(OP_POP, 8'd0, 16'd0, 16'd0);
      send_gapped(OP_POP, 8'hFF, 16'hFFFF, 16'hFFFF);

      // Random part in rounds: fill-heavy rounds run into push on full,
      // drain-heavy rounds into pop on empty, mixed rounds churn the middle.
      // Narrow priority rounds pile up ties so the sequence order matters.
      issued = 0;
      while (issued < RANDOM_ITEMS) begin
         mode = $urandom_range(MODE_FILL, MODE_MIXED);
         prio_style = $urandom_range(PRIO_WIDE, PRIO_EXTREMES);
         prio_base = 8'($urandom_range(0, 255));
         idle_on = ($urandom_range(0, 3) != 0);
         run = $urandom_range(30, 110);
         case (mode)
            MODE_FILL:  push_pct = 85;
            MODE_DRAIN: push_pct = 15;
            default:    push_pct = 50;
         endcase
         for (k = 0; k < run && issued < RANDOM_ITEMS; k++) begin
            op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
            send_item(op, pick_priority(prio_style, prio_base),
                      16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
            issued++;
            idle_after(idle_on);
         end
      end

      @(negedge clock);
      req_valid = 1'b0;

      // drain: all results in, then a few quiet cycles for anything stray
      while (ledger.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (ledger.errors == 0 && ledger.pending() == 0) begin
         $display("priority_job_heap_scheduler test passed");
      end else begin
         $display("priority_job_heap_scheduler test failed");
      end
      $finish;
   end

endmodule
